@@ rtl/assert_macros.svh @@
// Assertion macros used by itoa_back.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// Implication checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ rtl/itoa_pkg.sv @@
package itoa_pkg;

  // Radix codes of an item.
  localparam logic [1:0] RADIX_SDEC = 2'd0;
  localparam logic [1:0] RADIX_UDEC = 2'd1;
  localparam logic [1:0] RADIX_OCT  = 2'd2;
  localparam logic [1:0] RADIX_HEX  = 2'd3;

  localparam int TEXT_MAX    = 22;
  localparam int STORE_DEPTH = 23;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_MINUS = 8'h2d;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_A     = 8'h61;

  // Classified work handed from the front to the back.
  typedef struct packed {
    logic [63:0] mag;
    logic [1:0]  radix_mode;
    logic        neg;
    logic [5:0]  width;
    logic        zero_pad;
    logic        left_justify;
  } job_t;

  // Digit value to ASCII.
  function automatic logic [7:0] digit_char(input logic [3:0] d);
    if (d < 4'd10) return CHAR_ZERO + {4'd0, d};
    return CHAR_A + {4'd0, d} - 8'd10;
  endfunction

endpackage

@@ rtl/itoa_front.sv @@
module itoa_front
  import itoa_pkg::*;
#(
  parameter int MAX_WIDTH  = 63,
  parameter int VALUE_BITS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] value,
  input  logic [1:0]  radix_mode,
  input  logic        wide_operand,
  input  logic [5:0]  field_width,
  input  logic        zero_pad,
  input  logic        left_justify,
  output logic        job_valid,
  input  logic        job_ready,
  output job_t        job
);

  localparam logic [63:0] WideMask = {64{1'b1}} >> (64 - VALUE_BITS);
  localparam logic [5:0]  MaxW     = 6'(MAX_WIDTH);

  logic [63:0] x;
  logic        sign;
  job_t        job_next;

  // Mask the operand, take the sign and the magnitude, cap the width.
  always_comb begin
    x    = wide_operand ? (value & WideMask) : {32'd0, value[31:0]};
    sign = wide_operand ? value[VALUE_BITS-1] : value[31];
    job_next.radix_mode   = radix_mode;
    job_next.neg          = (radix_mode == RADIX_SDEC) && sign;
    job_next.mag          = job_next.neg ?
                            ((~x + 64'd1) & (wide_operand ? WideMask : 64'hffff_ffff)) : x;
    job_next.width        = (field_width > MaxW) ? MaxW : field_width;
    job_next.zero_pad     = zero_pad;
    job_next.left_justify = left_justify;
  end

  // One-entry queue register between the front and the back.
  assign in_ready = !job_valid || job_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (in_ready) begin
      job_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      job <= job_next;
    end
  end

endmodule

@@ rtl/itoa_back.sv @@
`include "assert_macros.svh"
module itoa_back
  import itoa_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       job_valid,
  output logic       job_ready,
  input  job_t       job,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] character,
  output logic       last_char
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  // Reciprocal of ten scaled by 2^23; exact for dividends below 2^20.
  localparam logic [19:0] RECIP_TEN = 20'd838861;

  logic [1:0]  state;
  logic [63:0] mag;
  logic        done_div;
  job_t        cur;
  logic [7:0]  rev [STORE_DEPTH];
  logic [4:0]  digit_count;
  logic [4:0]  count_inc;
  logic [5:0]  emit_position;
  logic [5:0]  total;
  logic [5:0]  pad;
  logic [3:0]  d;
  logic [63:0] q;
  logic [5:0]  k;
  logic [5:0]  idx;
  logic [7:0]  c_next;

  // Divide by ten, 16 bits of the dividend per cycle.
  // The remainder so far and the next chunk form a 20-bit dividend that is
  // divided by a reciprocal multiplication.
  logic [2:0]  dstep;
  logic [3:0]  rem;
  logic [63:0] quo;
  logic [19:0] num;
  logic [39:0] prod;
  logic [15:0] qc;
  logic [19:0] rsub;

  assign num  = {rem, quo[63:48]};
  assign prod = num * RECIP_TEN;
  assign qc   = prod[38:23];
  assign rsub = num - {1'b0, qc, 3'b000} - {3'b000, qc, 1'b0};

  // Digit and remaining value of the current step: shifted for octal and hexadecimal, from the divider for decimal.
  always_comb begin
    q = '0; d = '0;
    case (cur.radix_mode)
      RADIX_OCT: begin d = {1'b0, mag[2:0]}; q = mag >> 3; end
      RADIX_HEX: begin d = mag[3:0];         q = mag >> 4; end
      default:   begin d = rem;              q = quo;      end
    endcase
  end

  assign done_div  = (dstep == 3'd4);
  assign count_inc = digit_count + 5'd1;
  assign pad   = (cur.width > {1'b0, digit_count}) ? cur.width - {1'b0, digit_count} : 6'd0;
  assign total = {1'b0, digit_count} + pad;
  assign job_ready = (state == ST_IDLE);

  // Character at emit position k.
  assign k = emit_position;
  always_comb begin
    idx = 6'd0;
    if (cur.left_justify) begin
      if (k < {1'b0, digit_count}) begin
        idx = k; c_next = 8'd0;
      end else begin
        c_next = CHAR_SPACE;
      end
    end else if (k < pad) begin
      c_next = cur.zero_pad ? CHAR_ZERO : CHAR_SPACE;
    end else begin
      idx = k - pad; c_next = 8'd0;
    end
  end

  logic use_store;
  assign use_store = (cur.left_justify && k < {1'b0, digit_count}) ||
                     (!cur.left_justify && k >= pad);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      digit_count <= '0;
      emit_position <= '0;
      out_valid <= 1'b0;
      dstep <= '0;
    end else begin
      if (out_valid && out_ready && state != ST_EMIT) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (job_valid) begin
            cur <= job;
            mag <= job.mag;
            digit_count <= '0;
            dstep <= '0;
            rem <= '0;
            quo <= job.mag;
            state <= ST_CONV;
          end
        end
        ST_CONV: begin
          if (cur.radix_mode[1] == 1'b0 && !done_div) begin
            // One 16-bit chunk of the divide by ten per cycle.
            rem <= rsub[3:0];
            quo <= {quo[47:0], qc};
            dstep <= dstep + 3'd1;
          end else begin
            rev[digit_count] <= digit_char(d);
            mag <= q;
            quo <= q;
            rem <= '0;
            dstep <= '0;
            if (q == 64'd0 || count_inc == 5'(TEXT_MAX)) begin
              if (cur.neg) begin
                rev[count_inc] <= CHAR_MINUS;
                digit_count <= digit_count + 5'd2;
              end else begin
                digit_count <= count_inc;
              end
              emit_position <= '0;
              state <= ST_EMIT;
            end else begin
              digit_count <= count_inc;
            end
          end
        end
        ST_EMIT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            character <= use_store ? rev[5'(digit_count - 5'd1 - idx[4:0])] : c_next;
            last_char <= (emit_position + 6'd1 == total);
            emit_position <= emit_position + 6'd1;
            if (emit_position + 6'd1 == total) state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `ASSERT_IMPL(a_count_cap, clk, rst, state == ST_EMIT, digit_count <= 5'(STORE_DEPTH), "digit count over store depth")
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(character) && $stable(last_char), "output item changed while waiting")
  `ASSERT_IMPL(a_emit_bound, clk, rst, state == ST_EMIT, emit_position < total, "emit past total")

endmodule

@@ rtl/integer_to_padded_ascii.sv @@
// The input is held in a one-entry queue register; the back end takes the queued item
// when idle, converts it digit by digit (octal/hex by shifts, decimal by a divide by ten
// in 16-bit chunks) and then emits the characters, held by output stalls. A new item can
// wait in the queue meanwhile; the back end takes it once the last character is put out.
// Reset: synchronous rst clears the queue and the emit sequencer; store undefined.
module integer_to_padded_ascii
  import itoa_pkg::*;
#(
  parameter int MAX_WIDTH  = 63,
  parameter int VALUE_BITS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // value[63:0], radix_mode[65:64], wide_operand[66], field_width[72:67],
  // zero_pad[73], left_justify[74], zeros up to 79.
  input  logic [79:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // character[7:0].
  output logic [7:0]  m_axis_tdata,
  output logic        m_axis_tlast
);

  logic job_valid;
  logic job_ready;
  job_t job;

  itoa_front #(.MAX_WIDTH(MAX_WIDTH), .VALUE_BITS(VALUE_BITS)) u_front (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .value(s_axis_tdata[63:0]), .radix_mode(s_axis_tdata[65:64]),
    .wide_operand(s_axis_tdata[66]), .field_width(s_axis_tdata[72:67]),
    .zero_pad(s_axis_tdata[73]), .left_justify(s_axis_tdata[74]),
    .job_valid, .job_ready, .job
  );

  itoa_back u_back (
    .clk, .rst, .job_valid, .job_ready, .job,
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .character(m_axis_tdata), .last_char(m_axis_tlast)
  );

endmodule

@@ sim/integer_to_padded_ascii_tb.sv @@
module integer_to_padded_ascii_tb;
  import itoa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_W = 63;

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } char_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;

  logic [79:0] pending_items[$];
  char_t       expected_chars[$];
  int          failures = 0;
  int          item_count = 0;
  bit          quiet_phase = 0;
  int          hold_off = 0;
  bit          stim_done = 0;

  integer_to_padded_ascii DUT (.*);

  // Clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Builds the expected text of one item and appends it to the queue.
  task automatic predict_text(input logic [79:0] it);
    logic [63:0] raw, x, mag;
    logic [1:0]  mode;
    logic        wide, zp, lj, neg;
    logic [5:0]  fw;
    logic [7:0]  txt[$];
    int          len, pad, total, d, w;
    char_t       c;
    raw = it[63:0]; mode = it[65:64]; wide = it[66];
    fw = it[72:67]; zp = it[73]; lj = it[74];
    w = (int'(fw) > MAX_W) ? MAX_W : int'(fw);
    x = wide ? raw : {32'd0, raw[31:0]};
    mag = x; neg = 1'b0;
    if (mode == RADIX_SDEC && (wide ? x[63] : x[31])) begin
      neg = 1'b1;
      mag = wide ? (~x + 64'd1) : {32'd0, (~x[31:0] + 32'd1)};
    end
    do begin
      if (mode == RADIX_OCT) begin
        d = int'(mag[2:0]); mag = mag >> 3;
      end else if (mode == RADIX_HEX) begin
        d = int'(mag[3:0]); mag = mag >> 4;
      end else begin
        d = int'(mag % 64'd10); mag = mag / 64'd10;
      end
      txt.push_front(d < 10 ? CHAR_ZERO + 8'(d) : CHAR_A + 8'(d - 10));
    end while (mag != 0 && txt.size() < TEXT_MAX);
    if (neg) txt.push_front(CHAR_MINUS);
    len = txt.size();
    pad = (w > len) ? w - len : 0;
    total = len + pad;
    for (int k = 0; k < total; k++) begin
      if (lj) c.ch = (k < len) ? txt[k] : CHAR_SPACE;
      else if (k < pad) c.ch = zp ? CHAR_ZERO : CHAR_SPACE;
      else c.ch = txt[k - pad];
      c.last = (k + 1 == total);
      expected_chars.push_back(c);
    end
  endtask

  function automatic logic [79:0] pack_item(logic [63:0] v, logic [1:0] m, logic w,
                                            logic [5:0] fw, logic zp, logic lj);
    return {5'd0, lj, zp, fw, w, m, v};
  endfunction

  // Stimulus: directed corner cases, then random items with biased values.
  initial begin
    logic [63:0] v;
    pending_items.push_back(pack_item(64'd0, RADIX_SDEC, 1'b0, 6'd0, 1'b0, 1'b0));
    pending_items.push_back(pack_item(64'h8000_0000, RADIX_SDEC, 1'b0, 6'd0, 1'b0, 1'b0));
    pending_items.push_back(pack_item(64'h8000_0000_0000_0000, RADIX_SDEC, 1'b1, 6'd25,
                                      1'b1, 1'b0));
    pending_items.push_back(pack_item('1, RADIX_UDEC, 1'b1, 6'd63, 1'b0, 1'b0));
    pending_items.push_back(pack_item('1, RADIX_OCT, 1'b1, 6'd0, 1'b0, 1'b1));
    pending_items.push_back(pack_item('1, RADIX_HEX, 1'b1, 6'd63, 1'b1, 1'b1));
    pending_items.push_back(pack_item('1, RADIX_SDEC, 1'b0, 6'd10, 1'b1, 1'b0));
    pending_items.push_back(pack_item('1, RADIX_OCT, 1'b0, 6'd5, 1'b1, 1'b0));
    pending_items.push_back(pack_item(64'hffff_ffff_0000_0001, RADIX_HEX, 1'b0, 6'd3,
                                      1'b0, 1'b0));
    pending_items.push_back(pack_item(64'h7fff_ffff_ffff_ffff, RADIX_SDEC, 1'b1, 6'd1,
                                      1'b0, 1'b1));
    pending_items.push_back(pack_item(64'd9, RADIX_UDEC, 1'b0, 6'd2, 1'b1, 1'b1));
    pending_items.push_back(pack_item(64'hffff_ffff_ffff_fff6, RADIX_SDEC, 1'b1, 6'd6,
                                      1'b1, 1'b0));
    for (int i = 0; i < 480; i++) begin
      case ($urandom_range(0, 3))
        0: v = {$urandom, $urandom};
        1: v = 64'($urandom_range(0, 1000));
        2: v = -64'($urandom_range(1, 1000));
        default: v = {$urandom, $urandom} >> $urandom_range(0, 63);
      endcase
      // Most items use small widths so that long texts stay rare.
      pending_items.push_back(pack_item(v, 2'($urandom_range(0, 3)), 1'($urandom),
                                        ($urandom_range(0, 9) == 0) ? 6'($urandom) :
                                        6'($urandom_range(0, 12)),
                                        1'($urandom), 1'($urandom)));
    end
  end

  // Driver.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) predict_text(s_axis_tdata);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_items.size() > 0 && (quiet_phase || $urandom_range(0, 99) >= 9)) begin
          s_axis_tdata  <= pending_items.pop_front();
          s_axis_tvalid <= 1'b1;
          item_count++;
        end else begin
          s_axis_tvalid <= 1'b0;
          if (pending_items.size() == 0 && !(s_axis_tvalid && !s_axis_tready))
            stim_done <= 1'b1;
        end
      end
    end
  end

  // Quiet stretch, set by the item count, and receiver hold-off, counted in cycles.
  always @(posedge clk) begin
    if (item_count >= 150 && item_count < 230) quiet_phase <= 1'b1;
    else quiet_phase <= 1'b0;
    if (item_count == 60 && hold_off == 0) hold_off <= 1;
    else if (hold_off > 0 && hold_off < 3000) hold_off <= hold_off + 1;
  end

  // Monitor and ready generator.
  always @(posedge clk) begin
    char_t exp_c;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_chars.size() == 0) begin
          $error("unexpected character %h", m_axis_tdata);
          failures++;
        end else begin
          exp_c = expected_chars.pop_front();
          if (m_axis_tdata !== exp_c.ch) begin
            $error("character: expected %h actual %h", exp_c.ch, m_axis_tdata);
            failures++;
          end
          if (m_axis_tlast !== exp_c.last) begin
            $error("last_char: expected %b actual %b", exp_c.last, m_axis_tlast);
            failures++;
          end
        end
      end
      if (hold_off > 0 && hold_off < 3000) m_axis_tready <= 1'b0;
      else m_axis_tready <= quiet_phase || ($urandom_range(0, 99) >= 9);
    end
  end

  // Reset, completion and final verdict.
  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    wait (stim_done);
    @(posedge clk);
    wait (expected_chars.size() == 0);
    repeat (200) @(posedge clk);
    if (failures == 0 && expected_chars.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Timeout.
  initial begin
    #8ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule
